[rtl/ssnf_pkg.sv]
// Shared types, segment codes and glyph lookup for the seven-segment number formatter.
package ssnf_pkg;

    localparam int ValueWidth = 17;
    localparam int SegWidth   = 8;
    localparam int MagWidth   = 16;
    localparam int DecWidth   = 14;

    localparam logic [SegWidth-1:0] SEG_BLANK = 8'h00;
    localparam logic [SegWidth-1:0] SEG_MINUS = 8'h02;

    localparam logic signed [ValueWidth-1:0] DEC_MIN = -17'sd999;
    localparam logic signed [ValueWidth-1:0] DEC_MAX = 17'sd9999;
    localparam logic signed [ValueWidth-1:0] HEX_MIN = -17'sd4095;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic                         hex_mode;
    } ssnf_in_t;

    typedef struct packed {
        logic [SegWidth-1:0] seg_left;
        logic [SegWidth-1:0] seg_mid_left;
        logic [SegWidth-1:0] seg_mid_right;
        logic [SegWidth-1:0] seg_right;
        logic                out_of_range;
    } ssnf_out_t;

    function automatic logic [SegWidth-1:0] glyph(input logic [3:0] digit);
        logic [SegWidth-1:0] code;
        case (digit)
            4'h0:    code = 8'hFC;
            4'h1:    code = 8'h60;
            4'h2:    code = 8'hDA;
            4'h3:    code = 8'hF2;
            4'h4:    code = 8'h66;
            4'h5:    code = 8'hB6;
            4'h6:    code = 8'hBE;
            4'h7:    code = 8'hE0;
            4'h8:    code = 8'hFE;
            4'h9:    code = 8'hF6;
            4'hA:    code = 8'hEE;
            4'hB:    code = 8'h3E;
            4'hC:    code = 8'h9C;
            4'hD:    code = 8'h7A;
            4'hE:    code = 8'h9E;
            default: code = 8'h8E;
        endcase
        return code;
    endfunction

endpackage

[rtl/seven_segment_number_formatter_top.sv]
// Top level: input register, conversion logic and result register with valid/stall flow.
// Converts a signed 17-bit value to four seven-segment codes in decimal or hex, one
// transfer per clock unless the result side stalls. An accepted item is held in the
// input register, and the result register takes its codes when the result side is
// not stalled. Result valid rises with them, and the result can then be transferred.
// Throughput is one item per cycle whenever the result side is not stalled. Values outside
// -999..9999 (decimal) or -0xFFF..0xFFFF (hex) give out_of_range with all segments zero.
module seven_segment_number_formatter_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ssnf_pkg::ssnf_in_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output ssnf_pkg::ssnf_out_t result
);

    logic                in_valid_reg;
    ssnf_pkg::ssnf_in_t  in_data_reg;
    logic                out_valid_reg;
    ssnf_pkg::ssnf_out_t out_data_reg;
    ssnf_pkg::ssnf_out_t out_data_next;
    logic                out_advance;
    logic                in_advance;

    assign out_advance = !out_valid_reg || !result_stall;
    assign in_advance  = !in_valid_reg || out_advance;
    assign item_stall  = !in_advance;

    ssnf_encode u_encode
    (
        .item   (in_data_reg),
        .result (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
                in_valid_reg <= item_valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && item_valid)
            in_data_reg <= item;
        if (out_advance && in_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

[rtl/ssnf_encode.sv]
// Combinational value-to-segment conversion: range check, sign, digit split, blanking.
module ssnf_encode
(
    input  ssnf_pkg::ssnf_in_t  item,
    output ssnf_pkg::ssnf_out_t result
);

    logic                                  neg;
    logic                                  bad;
    logic signed [ssnf_pkg::ValueWidth-1:0] neg_value;
    logic [ssnf_pkg::MagWidth-1:0]         mag;
    logic [ssnf_pkg::DecWidth-1:0]         mag_dec;
    logic [26:0]                           prod1;
    logic [26:0]                           prod2;
    logic [27:0]                           prod3;
    logic [9:0]                            q1;
    logic [6:0]                            q2;
    logic [3:0]                            q3;
    logic [3:0]                            dec_d [4];
    logic [3:0]                            dig   [4];
    logic                                  show  [4];
    logic [ssnf_pkg::SegWidth-1:0]         pos   [4];

    always_comb
    begin
        neg       = item.value[ssnf_pkg::ValueWidth-1];
        neg_value = -item.value;
        mag       = neg ? neg_value[ssnf_pkg::MagWidth-1:0]
                        : item.value[ssnf_pkg::MagWidth-1:0];

        if (item.hex_mode)
            bad = item.value < ssnf_pkg::HEX_MIN;
        else
            bad = (item.value < ssnf_pkg::DEC_MIN) || (item.value > ssnf_pkg::DEC_MAX);

        // reciprocal multiply for /10, /100, /1000; exact for mag <= 9999
        mag_dec = mag[ssnf_pkg::DecWidth-1:0];
        prod1   = 27'(mag_dec) * 27'd6554;
        prod2   = 27'(mag_dec) * 27'd5243;
        prod3   = 28'(mag_dec) * 28'd8389;
        q1      = prod1[25:16];
        q2      = prod2[25:19];
        q3      = prod3[26:23];

        dec_d[0] = 4'(mag_dec - ((14'(q1) << 3) + (14'(q1) << 1)));
        dec_d[1] = 4'(q1 - ((10'(q2) << 3) + (10'(q2) << 1)));
        dec_d[2] = 4'(q2 - ((7'(q3) << 3) + (7'(q3) << 1)));
        dec_d[3] = q3;

        if (item.hex_mode)
        begin
            dig[0]  = mag[3:0];
            dig[1]  = mag[7:4];
            dig[2]  = mag[11:8];
            dig[3]  = mag[15:12];
            show[1] = mag[15:4] != '0;
            show[2] = mag[15:8] != '0;
            show[3] = mag[15:12] != '0;
        end
        else
        begin
            dig     = dec_d;
            show[1] = mag >= 16'd10;
            show[2] = mag >= 16'd100;
            show[3] = mag >= 16'd1000;
        end
        show[0] = 1'b1;

        // pos[0] is leftmost, dig[0] is least significant
        for (int i = 0; i < 4; i++)
            pos[3-i] = show[i] ? ssnf_pkg::glyph(dig[i]) : ssnf_pkg::SEG_BLANK;
        if (neg)
            pos[0] = ssnf_pkg::SEG_MINUS;

        if (bad)
        begin
            result.seg_left      = '0;
            result.seg_mid_left  = '0;
            result.seg_mid_right = '0;
            result.seg_right     = '0;
        end
        else
        begin
            result.seg_left      = pos[0];
            result.seg_mid_left  = pos[1];
            result.seg_mid_right = pos[2];
            result.seg_right     = pos[3];
        end
        result.out_of_range = bad;
    end

endmodule
